// ===== rtl/utf8_sanitize_escape_top_assert.svh =====
// ---------------------------------------------------------------------------
// utf8_sanitize_escape_top_assert.svh
// Assertion macros for the sanitizer RTL.
// ---------------------------------------------------------------------------
`ifndef UTF8_SANITIZE_ESCAPE_TOP_ASSERT_SVH
`define UTF8_SANITIZE_ESCAPE_TOP_ASSERT_SVH

// same-cycle implication
`define U8SE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define U8SE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/u8se_pkg.sv =====
// ---------------------------------------------------------------------------
// u8se_pkg
// Types, constants and byte classification for the UTF-8 sanitizer.
// ---------------------------------------------------------------------------
package u8se_pkg;

    localparam logic [7:0] ESC_LEAD  = 8'hED;
    localparam logic [7:0] ESC_MID   = 8'hAC;
    localparam logic [7:0] CONT_BASE = 8'h80;
    localparam logic [7:0] LOW6_MASK = 8'h3F;
    localparam logic [7:0] SURR_LO   = 8'hA0;
    localparam logic [7:0] SURR_HI   = 8'hBF;

    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_MID   = 2'd1;
    localparam logic [1:0] PH_LAST  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_JUDGE,
        ST_EMIT,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        DEC_NONE,
        DEC_WAIT,
        DEC_EMIT
    } dec_kind_t;

    typedef struct packed {
        logic load;
        logic latch;
        logic emit;
        logic flush;
    } cmd_t;

    typedef struct packed {
        dec_kind_t kind;
        logic      emit_last;
        logic      pend_valid;
        logic      out_free;
    } sts_t;

    function automatic logic [2:0] seq_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (!b[7])                       len = 3'd1;
        else if (b[7:3] == 5'h1E)        len = 3'd4;
        else if (b[7:4] == 4'h0E)        len = 3'd3;
        else if (b[7:5] == 3'h06)        len = 3'd2;
        return len;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & 8'hC0) == CONT_BASE;
    endfunction

    function automatic logic seq_bad(input logic [2:0] len, input logic [7:0] c1,
                                     input logic [7:0] c2);
        logic bad;
        bad = 1'b0;
        unique case (len)
            3'd2: bad = (c1 & 8'h1E) == 8'h00;
            3'd3: bad = (((c1 & 8'h0F) == 8'h00) && ((c2 & 8'h20) == 8'h00)) ||
                        (c1 == ESC_LEAD && c2 >= SURR_LO && c2 <= SURR_HI);
            3'd4: bad = (((c1 & 8'h07) == 8'h00) && ((c2 & 8'h30) == 8'h00)) ||
                        (((c1 & 8'h04) != 8'h00) &&
                         (((c1 & 8'h03) != 8'h00) || ((c2 & 8'h30) != 8'h00)));
            default: bad = 1'b0;
        endcase
        return bad;
    endfunction

endpackage

// ===== rtl/u8se_ctrl.sv =====
// ---------------------------------------------------------------------------
// u8se_ctrl
// Sequencer: accept, judge the held group, emit beats, close the run.
// ---------------------------------------------------------------------------
module u8se_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  u8se_pkg::sts_t sts,
    output u8se_pkg::cmd_t cmd
);

    u8se_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= u8se_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            u8se_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = u8se_pkg::ST_JUDGE;
                end
            end
            u8se_pkg::ST_JUDGE: begin
                if (sts.kind == u8se_pkg::DEC_EMIT) begin
                    cmd.latch  = 1'b1;
                    state_next = u8se_pkg::ST_EMIT;
                end else begin
                    state_next = u8se_pkg::ST_FLUSH;
                end
            end
            u8se_pkg::ST_EMIT: begin
                if (!sts.pend_valid || sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.emit_last) begin
                        state_next = u8se_pkg::ST_JUDGE;
                    end
                end
            end
            u8se_pkg::ST_FLUSH: begin
                if (!sts.pend_valid) begin
                    state_next = u8se_pkg::ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = u8se_pkg::ST_IDLE;
                end
            end
            default: state_next = u8se_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/u8se_dp.sv =====
// ---------------------------------------------------------------------------
// u8se_dp
// Hold buffer, sequence judgment, escape expansion and output registers.
// ---------------------------------------------------------------------------
module u8se_dp (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [7:0]     s_tdata,
    input  logic           s_tlast,
    output logic [7:0]     m_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic           m_tlast,
    output logic           m_tuser,
    input  u8se_pkg::cmd_t cmd,
    output u8se_pkg::sts_t sts
);

    logic [7:0] hold_reg [4];
    logic [2:0] cnt_reg;
    logic       end_reg;
    logic [2:0] rem_reg;
    logic       esc_reg;
    logic [1:0] phase_reg;
    logic       pend_valid_reg;
    logic [7:0] pend_byte_reg;
    logic       m_valid_reg;
    logic [7:0] m_byte_reg;
    logic       m_run_last_reg;
    logic       m_done_reg;

    u8se_pkg::dec_kind_t dec_kind;
    logic [2:0] dec_n;
    logic       dec_esc;
    logic [2:0] lead_len;
    logic [2:0] bad_idx;
    logic [7:0] beat;
    logic       byte_end;
    logic       out_free;
    logic       push_out;

    // judgment of the group at the front of the buffer
    always_comb begin
        lead_len = u8se_pkg::seq_length(hold_reg[0]);
        bad_idx  = 3'd0;
        dec_kind = u8se_pkg::DEC_NONE;
        dec_n    = 3'd0;
        dec_esc  = 1'b0;
        for (int i = 1; i < 4; i++) begin
            if (3'(i) < lead_len && bad_idx == 3'd0 && !u8se_pkg::is_cont(hold_reg[i])) begin
                bad_idx = 3'(i);
            end
        end
        if (cnt_reg == 3'd0) begin
            dec_kind = u8se_pkg::DEC_NONE;
        end else if (lead_len == 3'd0) begin
            dec_kind = u8se_pkg::DEC_EMIT;
            dec_n    = 3'd1;
            dec_esc  = 1'b1;
        end else if (lead_len > cnt_reg) begin
            if (end_reg) begin
                dec_kind = u8se_pkg::DEC_EMIT;
                dec_n    = cnt_reg;
                dec_esc  = 1'b1;
            end else begin
                dec_kind = u8se_pkg::DEC_WAIT;
            end
        end else if (bad_idx != 3'd0) begin
            dec_kind = u8se_pkg::DEC_EMIT;
            dec_n    = bad_idx;
            dec_esc  = 1'b1;
        end else begin
            dec_kind = u8se_pkg::DEC_EMIT;
            dec_n    = lead_len;
            dec_esc  = u8se_pkg::seq_bad(lead_len, hold_reg[0], hold_reg[1]);
        end
    end

    // escape expansion of the front byte
    always_comb begin
        case (phase_reg)
            u8se_pkg::PH_FIRST: beat = esc_reg ? u8se_pkg::ESC_LEAD : hold_reg[0];
            u8se_pkg::PH_MID:   beat = u8se_pkg::ESC_MID + {6'd0, hold_reg[0][7:6]};
            default:            beat = u8se_pkg::CONT_BASE |
                                       (hold_reg[0] & u8se_pkg::LOW6_MASK);
        endcase
        byte_end = esc_reg ? (phase_reg == u8se_pkg::PH_LAST)
                           : (phase_reg == u8se_pkg::PH_FIRST);
    end

    assign out_free = !m_valid_reg || m_tready;
    assign push_out = (cmd.emit && pend_valid_reg) || cmd.flush;

    assign sts.kind       = dec_kind;
    assign sts.emit_last  = byte_end && (rem_reg == 3'd1);
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= 3'd0;
            rem_reg        <= 3'd0;
            phase_reg      <= u8se_pkg::PH_FIRST;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.load) begin
                cnt_reg <= cnt_reg + 3'd1;
            end
            if (cmd.latch) begin
                rem_reg   <= dec_n;
                phase_reg <= u8se_pkg::PH_FIRST;
            end
            if (cmd.emit) begin
                pend_valid_reg <= 1'b1;
                if (byte_end) begin
                    phase_reg <= u8se_pkg::PH_FIRST;
                    cnt_reg   <= cnt_reg - 3'd1;
                    rem_reg   <= rem_reg - 3'd1;
                end else begin
                    phase_reg <= phase_reg + 2'd1;
                end
            end
            if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end
            if (push_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            hold_reg[cnt_reg[1:0]] <= s_tdata;
            end_reg                <= s_tlast;
        end
        if (cmd.latch) begin
            esc_reg <= dec_esc;
        end
        if (cmd.emit) begin
            pend_byte_reg <= beat;
            if (byte_end) begin
                for (int i = 0; i < 3; i++) begin
                    hold_reg[i] <= hold_reg[i + 1];
                end
            end
        end
        if (push_out) begin
            m_byte_reg     <= pend_byte_reg;
            m_run_last_reg <= cmd.flush;
            m_done_reg     <= cmd.flush && end_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_run_last_reg;
    assign m_tlast  = m_done_reg;

endmodule

// ===== rtl/utf8_sanitize_escape_top.sv =====
// ---------------------------------------------------------------------------
// utf8_sanitize_escape_top
// UTF-8 sanitizer: well-formed sequences pass, bad bytes become 3-byte escapes.
//
//   channel  dir  tdata            tlast        tuser
//   s_       in   in_byte[7:0]     in_end       -
//   m_       out  out_byte[7:0]    string_done  run_last
//
// One input beat at a time; s_tready is high only while idle.
// Each input beat is loaded, then each group is judged and its output beats
// are emitted (1 per passed byte, 3 per escaped byte) before the run closes.
// Each output beat waits in a pending register so run_last is known; the next
// beat pushes it out, and the last beat of a run leaves on the final flush.
// Back-pressure on m_ stalls the emit sequencer; the output register decouples.
// Reset (aresetn low, synchronous) empties the hold buffer and the output stage.
// ---------------------------------------------------------------------------
module utf8_sanitize_escape_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       s_tlast,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic       m_tlast,
    output logic       m_tuser    // [0] run_last
);

    u8se_pkg::cmd_t cmd;
    u8se_pkg::sts_t sts;

    u8se_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    u8se_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

`include "utf8_sanitize_escape_top_assert.svh"

    `U8SE_ASSERT_IMPL(a_done_is_run_last, m_tvalid && m_tlast, m_tuser, "done w/o run_last")
    `U8SE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready while busy")
    `U8SE_ASSERT_IMPL(a_push_needs_room, cmd.emit && sts.pend_valid, sts.out_free, "output overrun")

endmodule
